>>> sv/tups_pkg.sv
// Shared types, protocol codes and one's-complement helpers for the
// TCP/UDP pseudo-header sum block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tups_pkg;

    // Byte stream transfer: one packet byte and its end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // Result transfer: folded pseudo-header sum and status
    typedef struct packed {
        logic [15:0] initial_sum;
        logic [1:0]  status;
    } sum_item_t;

    // Packet summary captured on the last byte, handed from parser to finish stage
    typedef struct packed {
        logic [3:0]  version;
        logic [7:0]  protocol;
        logic [15:0] header_sum;
        logic [15:0] pseudo_sum;
        logic [15:0] l4_length;
    } pkt_summary_t;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_BAD_HDR = 2'd2;

    localparam logic [3:0] IP_VER_4 = 4'd4;
    localparam logic [3:0] IP_VER_6 = 4'd6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [15:0] HDR_SUM_GOOD = 16'hFFFF;

    // One's-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'h0000, s[16]};
    endfunction

    // Three-term one's-complement add, folded twice
    function automatic logic [15:0] oc_add3(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c);
        logic [17:0] s;
        logic [16:0] f;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        f = {1'b0, s[15:0]} + {15'h0000, s[17:16]};
        return f[15:0] + {15'h0000, f[16]};
    endfunction

endpackage

`default_nettype wire

>>> sv/tcp_udp_pseudo_header_sum.sv
// TCP/UDP pseudo-header sum over an IP packet byte stream: top level with
// summary and result registers. Depends on tups_pkg and tups_parser.
//
// Usage:
//   Byte channel (byte_valid / byte_stall / byte_item): one packet byte per
//   transfer, starting at IP header byte zero; last_byte marks the end.
//   Sum channel (sum_valid / sum_stall / sum_item): one result per packet,
//   the uncomplemented pseudo-header sum and a status code.
//   Throughput: one byte per cycle while byte_stall is low, sustained across
//   packet boundaries.
//   Path: the last byte's summary passes from the parser into the summary
//   register and then into the result register, which drives sum_valid.
//   Stall: while sum_stall holds a waiting result, one more finished packet
//   waits in the summary register; bytes keep flowing until that register is
//   also full and cannot advance, then byte_stall rises in the same cycle.
//   Reset: rst_n clears the parser state and both valid flags; the first
//   byte after reset is byte zero of a packet.
`timescale 1ns / 1ps
`default_nettype none

module tcp_udp_pseudo_header_sum
    import tups_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output      logic       byte_stall,
    input  wire byte_item_t byte_item,
    output      logic       sum_valid,
    input  wire logic       sum_stall,
    output      sum_item_t  sum_item
);

    pkt_summary_t summary;
    pkt_summary_t fin_reg;
    logic         fin_valid_reg, fin_valid_next;
    sum_item_t    out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    logic take;
    logic fin_move;
    logic fin_load;

    // Advance the summary into the result register when that slot is free or its result is being taken
    assign fin_move   = fin_valid_reg && (!out_valid_reg || !sum_stall);
    // Hold bytes only when the summary register is full and stuck
    assign byte_stall = fin_valid_reg && !fin_move;
    assign take       = byte_valid && !byte_stall;
    assign fin_load   = take && byte_item.last_byte;

    tups_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .item    (byte_item),
        .summary (summary)
    );

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (fin_load)
        begin
            fin_valid_next = 1'b1;
        end
        else if (fin_move)
        begin
            fin_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && sum_stall;
        if (fin_move)
        begin
            out_valid_next = 1'b1;
        end

        // Status precedence: bad version, then bad protocol, then IPv4 header sum
        out_next.status      = ST_VALID;
        out_next.initial_sum = 16'h0000;
        if ((fin_reg.version != IP_VER_4) && (fin_reg.version != IP_VER_6))
        begin
            out_next.status = ST_UNKNOWN;
        end
        else if ((fin_reg.protocol != PROTO_TCP) && (fin_reg.protocol != PROTO_UDP))
        begin
            out_next.status = ST_UNKNOWN;
        end
        else if ((fin_reg.version == IP_VER_4) && (fin_reg.header_sum != HDR_SUM_GOOD))
        begin
            out_next.status = ST_BAD_HDR;
        end
        else
        begin
            // IPv6 carries its length inside the pseudo sum already
            out_next.initial_sum = oc_add3(fin_reg.pseudo_sum, {8'h00, fin_reg.protocol},
                                           (fin_reg.version == IP_VER_4) ?
                                           fin_reg.l4_length : 16'h0000);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            fin_reg <= summary;
        end
        if (fin_move)
        begin
            out_reg <= out_next;
        end
    end

    assign sum_valid = out_valid_reg;
    assign sum_item  = out_reg;

    a_fail_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && (sum_item.status != ST_VALID)) |-> (sum_item.initial_sum == 16'h0000))
        else $error("nonzero sum with failing status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |-> ((sum_item.status == ST_VALID) || (sum_item.status == ST_UNKNOWN) ||
                       (sum_item.status == ST_BAD_HDR)))
        else $error("undefined status code");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sum_valid) |-> $past(fin_valid_reg))
        else $error("result without a pending summary");

    a_summary_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && !fin_move) |=> (fin_valid_reg && $stable(fin_reg)))
        else $error("blocked summary lost or changed");

endmodule

`default_nettype wire

>>> sv/tups_parser.sv
// Per-byte header parser: tracks byte position, version, IHL, protocol and
// running header and pseudo-header sums. Depends on tups_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tups_parser
    import tups_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire byte_item_t   item,
    output pkt_summary_t      summary
);

    localparam logic [5:0] IDX_V4_PROTO    = 6'd9;
    localparam logic [5:0] IDX_V6_NEXT_HDR = 6'd6;
    localparam logic [5:0] IDX_V4_ADDR_LO  = 6'd12;
    localparam logic [5:0] IDX_V4_ADDR_HI  = 6'd19;
    localparam logic [5:0] IDX_V6_LEN_LO   = 6'd4;
    localparam logic [5:0] IDX_V6_LEN_HI   = 6'd5;
    localparam logic [5:0] IDX_V6_ADDR_LO  = 6'd8;
    localparam logic [5:0] IDX_V6_ADDR_HI  = 6'd39;
    localparam logic [5:0] IDX_LAST_HDR    = 6'd63;

    logic [15:0] byte_count_reg,  byte_count_next;
    logic        past_header_reg, past_header_next;
    logic [3:0]  version_reg,     version_next;
    logic [3:0]  hdr_words_reg,   hdr_words_next;
    logic [7:0]  protocol_reg,    protocol_next;
    logic [7:0]  held_byte_reg,   held_byte_next;
    logic [15:0] hdr_sum_reg,     hdr_sum_next;
    logic [15:0] pseudo_sum_reg,  pseudo_sum_next;

    logic [5:0]  idx;
    logic [3:0]  ver;
    logic [3:0]  hw;
    logic        odd;
    logic        add_now;
    logic        in_pseudo;
    logic [15:0] word;

    always_comb
    begin
        idx     = byte_count_reg[5:0];
        ver     = (idx == 6'd0) ? item.data_byte[7:4] : version_reg;
        hw      = (idx == 6'd0) ? item.data_byte[3:0] : hdr_words_reg;
        odd     = idx[0];
        word    = odd ? {held_byte_reg, item.data_byte} : {item.data_byte, 8'h00};
        add_now = odd || item.last_byte;

        in_pseudo = ((ver == IP_VER_4) && (idx inside {[IDX_V4_ADDR_LO:IDX_V4_ADDR_HI]})) ||
                    ((ver == IP_VER_6) && ((idx inside {[IDX_V6_LEN_LO:IDX_V6_LEN_HI]}) ||
                                           (idx inside {[IDX_V6_ADDR_LO:IDX_V6_ADDR_HI]})));

        byte_count_next  = byte_count_reg + 16'd1;
        past_header_next = past_header_reg;
        version_next     = version_reg;
        hdr_words_next   = hdr_words_reg;
        protocol_next    = protocol_reg;
        held_byte_next   = held_byte_reg;
        hdr_sum_next     = hdr_sum_reg;
        pseudo_sum_next  = pseudo_sum_reg;

        // Bytes beyond the first 64 take no part in any sum
        if (!past_header_reg)
        begin
            version_next   = ver;
            hdr_words_next = hw;
            if (((ver == IP_VER_4) && (idx == IDX_V4_PROTO)) ||
                ((ver == IP_VER_6) && (idx == IDX_V6_NEXT_HDR)))
            begin
                protocol_next = item.data_byte;
            end
            if ((ver == IP_VER_4) && (idx < {hw, 2'b00}) && add_now)
            begin
                hdr_sum_next = oc_add(hdr_sum_reg, word);
            end
            if (in_pseudo && add_now)
            begin
                pseudo_sum_next = oc_add(pseudo_sum_reg, word);
            end
            if (!odd)
            begin
                held_byte_next = item.data_byte;
            end
            if (idx == IDX_LAST_HDR)
            begin
                past_header_next = 1'b1;
            end
        end

        summary.version    = version_next;
        summary.protocol   = protocol_next;
        summary.header_sum = hdr_sum_next;
        summary.pseudo_sum = pseudo_sum_next;
        summary.l4_length  = byte_count_next - {10'h000, hdr_words_next, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            past_header_reg <= 1'b0;
            version_reg     <= '0;
            hdr_words_reg   <= '0;
            protocol_reg    <= '0;
            held_byte_reg   <= '0;
            hdr_sum_reg     <= '0;
            pseudo_sum_reg  <= '0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                // Start clean for the next packet
                byte_count_reg  <= '0;
                past_header_reg <= 1'b0;
                version_reg     <= '0;
                hdr_words_reg   <= '0;
                protocol_reg    <= '0;
                held_byte_reg   <= '0;
                hdr_sum_reg     <= '0;
                pseudo_sum_reg  <= '0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                past_header_reg <= past_header_next;
                version_reg     <= version_next;
                hdr_words_reg   <= hdr_words_next;
                protocol_reg    <= protocol_next;
                held_byte_reg   <= held_byte_next;
                hdr_sum_reg     <= hdr_sum_next;
                pseudo_sum_reg  <= pseudo_sum_next;
            end
        end
    end

endmodule

`default_nettype wire
